/* design/sorted_priority_ready_queue_assert.svh */
// Assertion macros for the sorted priority ready queue.
`ifndef SORTED_PRIORITY_READY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_READY_QUEUE_ASSERT_SVH

// cond holds at every clock edge out of reset
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/spq_pkg.sv */
// Package: types and codes for the sorted priority ready queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } rec_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_id;
    logic [15:0] out_arrival;
    logic [15:0] out_burst;
    logic [7:0]  out_prio;
    logic [15:0] out_remaining;
    logic        now_empty;
    logic [4:0]  fill;
  } out_item_t;

endpackage

/* design/sorted_priority_ready_queue.sv */
// Sorted priority ready queue: record memory walked by a small sequencer.
//
//  channel  ports                     transfer
//  in       start, busy, in_item      edge with start high and busy low
//  out      out_valid, out_item       every edge that ends an out_valid cycle
//
// An item keeps busy high until it is done; the result is strobed in the
// first cycle with busy low. Full/empty cases and enqueue into an empty queue
// finish in the dispatch state; an insertion walk or a dequeue shift moves one
// record per cycle through the record memory (one registered read, one write).
// Reset (synchronous, rst_n low) empties the queue; memory is not cleared.
// The receiver cannot stall: each result is on the ports for one cycle only.
`timescale 1ns / 1ps
`include "sorted_priority_ready_queue_assert.svh"

module sorted_priority_ready_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::in_item_t in_item,
  output logic              out_valid,
  output spq_pkg::out_item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_ENQ_CMP,
    S_ENQ_PUT,
    S_DEQ_HEAD,
    S_DEQ_SHIFT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  spq_pkg::in_item_t  item_r, item_nxt;
  spq_pkg::rec_t      head_r, head_nxt;
  logic               out_valid_r, out_valid_nxt;
  spq_pkg::out_item_t out_r, out_nxt;

  // record memory
  spq_pkg::rec_t      mem [DEPTH];
  spq_pkg::rec_t      rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  spq_pkg::rec_t      mem_wd;
  logic [AW-1:0]      mem_ra;

  spq_pkg::rec_t      new_rec;
  logic               fin;
  logic [1:0]         fin_status;
  logic               fin_head;
  spq_pkg::rec_t      fin_rec;
  logic [CW+4:0]      fill_ext;
  logic [CW:0]        pos_inc;

  assign new_rec = '{proc_id:   item_r.proc_id,
                     arrival:   item_r.arrival,
                     burst:     item_r.burst,
                     prio:      item_r.prio,
                     remaining: item_r.remaining};
  assign pos_inc = {1'b0, {1'b0, pos_r} + CW'(1)};

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    head_nxt      = head_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = new_rec;
    mem_ra        = '0;
    fin           = 1'b0;
    fin_status    = spq_pkg::STATUS_DONE;
    fin_head      = 1'b0;
    fill_ext      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (item_r.opcode == spq_pkg::OP_ENQUEUE) begin
          if (occ_r == CW'(DEPTH)) begin
            fin        = 1'b1;
            fin_status = spq_pkg::STATUS_FULL;
          end else if (occ_r == '0) begin
            mem_we  = 1'b1;
            mem_wa  = '0;
            occ_nxt = occ_r + CW'(1);
            fin     = 1'b1;
          end else begin
            // walk down from the tail; read data lands in ENQ_CMP
            pos_nxt   = occ_r[AW-1:0];
            mem_ra    = occ_r[AW-1:0] - AW'(1);
            state_nxt = S_ENQ_CMP;
          end
        end else begin
          if (occ_r == '0) begin
            fin        = 1'b1;
            fin_status = spq_pkg::STATUS_EMPTY;
          end else begin
            mem_ra    = '0;
            state_nxt = S_DEQ_HEAD;
          end
        end
      end
      S_ENQ_CMP: begin
        // rd_data_r holds entry pos_r-1
        mem_we = 1'b1;
        mem_wa = pos_r;
        if (rd_data_r.prio > item_r.prio) begin
          mem_wd  = rd_data_r;
          pos_nxt = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = S_ENQ_PUT;
          end else begin
            mem_ra = pos_r - AW'(2);
          end
        end else begin
          occ_nxt = occ_r + CW'(1);
          fin     = 1'b1;
        end
      end
      S_ENQ_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = '0;
        occ_nxt = occ_r + CW'(1);
        fin     = 1'b1;
      end
      S_DEQ_HEAD: begin
        head_nxt = rd_data_r;
        if (occ_r == CW'(1)) begin
          occ_nxt  = '0;
          fin      = 1'b1;
          fin_head = 1'b1;
        end else begin
          mem_ra    = AW'(1);
          pos_nxt   = AW'(1);
          state_nxt = S_DEQ_SHIFT;
        end
      end
      S_DEQ_SHIFT: begin
        // rd_data_r holds entry pos_r; move it up one place
        mem_we = 1'b1;
        mem_wa = pos_r - AW'(1);
        mem_wd = rd_data_r;
        if (pos_inc < {1'b0, occ_r}) begin
          mem_ra  = pos_inc[AW-1:0];
          pos_nxt = pos_inc[AW-1:0];
        end else begin
          occ_nxt  = occ_r - CW'(1);
          fin      = 1'b1;
          fin_head = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_DEQ_HEAD) begin
      fin_rec = rd_data_r;
    end else begin
      fin_rec = head_r;
    end

    if (fin) begin
      fill_ext              = {5'b0, occ_nxt};
      state_nxt             = S_IDLE;
      out_valid_nxt         = 1'b1;
      out_nxt.status        = fin_status;
      out_nxt.out_id        = fin_head ? fin_rec.proc_id   : 8'd0;
      out_nxt.out_arrival   = fin_head ? fin_rec.arrival   : 16'd0;
      out_nxt.out_burst     = fin_head ? fin_rec.burst     : 16'd0;
      out_nxt.out_prio      = fin_head ? fin_rec.prio      : 8'd0;
      out_nxt.out_remaining = fin_head ? fin_rec.remaining : 16'd0;
      out_nxt.now_empty     = (occ_nxt == '0);
      out_nxt.fill          = fill_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    head_r <= head_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `SPQ_ASSERT_ALWAYS(a_occ_range, occ_r <= CW'(DEPTH), "occupancy above depth")
  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
                   "accepted item did not raise busy")
  `SPQ_ASSERT_IMPL(a_full_status, out_valid_r && out_r.status == spq_pkg::STATUS_FULL,
                   occ_r == CW'(DEPTH), "full status with room left")
  `SPQ_ASSERT_IMPL(a_empty_flag, out_valid_r, out_r.now_empty == (occ_r == '0),
                   "empty flag disagrees with occupancy")
  `SPQ_ASSERT_IMPL(a_shift_bound, state_r == S_DEQ_SHIFT, {1'b0, pos_r} < occ_r,
                   "shift index past occupancy")

endmodule

/* test/spq_ready_queue_checker.sv */
// Checker for the sorted priority ready queue: tracks expected results and compares transfers.
`timescale 1ns / 1ps

module spq_ready_queue_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  spq_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  spq_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 outstanding
);

  spq_pkg::rec_t      ready_recs [DEPTH];
  int                 ready_count;
  spq_pkg::out_item_t pending_results [$];
  int                 mismatches;

  // Sorted insert behind all equal-or-better priorities; dequeue pops the head.
  task automatic predict_queue_result(input spq_pkg::in_item_t it,
                                      output spq_pkg::out_item_t res);
    spq_pkg::rec_t nr;
    int            pos;
    res = '0;
    if (it.opcode == spq_pkg::OP_ENQUEUE) begin
      nr.proc_id   = it.proc_id;
      nr.arrival   = it.arrival;
      nr.burst     = it.burst;
      nr.prio      = it.prio;
      nr.remaining = it.remaining;
      if (ready_count >= DEPTH) begin
        res.status = spq_pkg::STATUS_FULL;
      end else begin
        pos = ready_count;
        while (pos > 0 && ready_recs[pos - 1].prio > nr.prio) begin
          ready_recs[pos] = ready_recs[pos - 1];
          pos--;
        end
        ready_recs[pos] = nr;
        ready_count++;
        res.status = spq_pkg::STATUS_DONE;
      end
    end else if (ready_count == 0) begin
      res.status = spq_pkg::STATUS_EMPTY;
    end else begin
      res.status        = spq_pkg::STATUS_DONE;
      res.out_id        = ready_recs[0].proc_id;
      res.out_arrival   = ready_recs[0].arrival;
      res.out_burst     = ready_recs[0].burst;
      res.out_prio      = ready_recs[0].prio;
      res.out_remaining = ready_recs[0].remaining;
      for (int i = 1; i < ready_count; i++) ready_recs[i - 1] = ready_recs[i];
      ready_count--;
    end
    res.now_empty = (ready_count == 0);
    res.fill      = 5'(ready_count);
  endtask

  always @(posedge clk) begin
    spq_pkg::out_item_t want;
    if (!rst_n) begin
      pending_results.delete();
      ready_count = 0;
    end else begin
      // result transfer is checked before a same-edge input transfer is predicted
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result %h", $realtime, out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status || out_item.out_id !== want.out_id ||
              out_item.out_arrival !== want.out_arrival ||
              out_item.out_burst !== want.out_burst ||
              out_item.out_prio !== want.out_prio ||
              out_item.out_remaining !== want.out_remaining ||
              out_item.now_empty !== want.now_empty || out_item.fill !== want.fill) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp st=%0d id=%h arr=%h bur=%h pri=%h rem=%h emp=%b fill=%0d",
                       $realtime, want.status, want.out_id, want.out_arrival,
                       want.out_burst, want.out_prio, want.out_remaining,
                       want.now_empty, want.fill);
              $display("%0t: mismatch got st=%0d id=%h arr=%h bur=%h pri=%h rem=%h emp=%b fill=%0d",
                       $realtime, out_item.status, out_item.out_id, out_item.out_arrival,
                       out_item.out_burst, out_item.out_prio, out_item.out_remaining,
                       out_item.now_empty, out_item.fill);
            end
          end
        end
      end
      if (start && !busy) begin
        predict_queue_result(in_item, want);
        pending_results.push_back(want);
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

/* test/sorted_priority_ready_queue_test.sv */
// Testbench top for the sorted priority ready queue: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module sorted_priority_ready_queue_test;

  localparam int QDEPTH = spq_pkg::DEPTH_DEF;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  spq_pkg::in_item_t  in_item;
  logic               out_valid;
  spq_pkg::out_item_t out_item;
  int                 fail_count;
  int                 outstanding;

  sorted_priority_ready_queue #(.DEPTH(QDEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  spq_ready_queue_checker #(.DEPTH(QDEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  function automatic spq_pkg::in_item_t random_fields();
    spq_pkg::in_item_t it;
    it.opcode    = 1'($urandom_range(0, 1));
    it.proc_id   = 8'($urandom_range(0, 255));
    it.arrival   = 16'($urandom_range(0, 65535));
    it.burst     = 16'($urandom_range(0, 65535));
    it.prio      = 8'($urandom_range(0, 255));
    it.remaining = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic spq_pkg::in_item_t make_enqueue(input logic [7:0] id,
                                                     input logic [15:0] arr,
                                                     input logic [15:0] bur,
                                                     input logic [7:0] pri,
                                                     input logic [15:0] rem);
    spq_pkg::in_item_t it;
    it.opcode    = spq_pkg::OP_ENQUEUE;
    it.proc_id   = id;
    it.arrival   = arr;
    it.burst     = bur;
    it.prio      = pri;
    it.remaining = rem;
    return it;
  endfunction

  // start stays high across back-to-back items; lowered only by a pause or a drain
  task automatic send_item(input spq_pkg::in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start   <= 1'b0;
    in_item <= random_fields();
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_queue_results();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    spq_pkg::in_item_t it;
    int                enq_pct;
    bit                gaps_on;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // dequeue on empty, with junk in the ignored record fields
    it = make_enqueue(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    it.opcode = spq_pkg::OP_DEQUEUE;
    send_item(it);
    // extremes, then ties at the lowest, middle and highest priority
    send_item(make_enqueue(8'h00, 16'h0000, 16'h0000, 8'hFF, 16'h0000));
    send_item(make_enqueue(8'hFF, 16'hFFFF, 16'hFFFF, 8'h00, 16'hFFFF));
    send_item(make_enqueue(8'h01, 16'h1111, 16'h2222, 8'h07, 16'h3333));
    send_item(make_enqueue(8'h02, 16'h4444, 16'h5555, 8'h07, 16'h6666));
    send_item(make_enqueue(8'h03, 16'h7777, 16'h8888, 8'h07, 16'h9999));
    send_item(make_enqueue(8'h04, 16'hAAAA, 16'hBBBB, 8'h00, 16'hCCCC));
    send_item(make_enqueue(8'h05, 16'hDDDD, 16'hEEEE, 8'hFF, 16'h5A5A));
    for (int i = 0; i < 9; i++)
      send_item(make_enqueue(8'(16 + i), 16'(i * 7001), 16'(65535 - i * 5003),
                             8'((i * 37) % 256), 16'(i * 4099)));
    // queue is full here: this one is dropped
    send_item(make_enqueue(8'hAB, 16'hCDEF, 16'h0123, 8'h00, 16'h4567));
    for (int i = 0; i < 4; i++) begin
      it = random_fields();
      it.opcode = spq_pkg::OP_DEQUEUE;
      send_item(it);
    end

    // random segments each pick an enqueue share, so the queue tends to fill or drain
    for (int seg = 0; seg < 14; seg++) begin
      case ($urandom_range(0, 3))
        0:       enq_pct = 15;
        1:       enq_pct = 50;
        2:       enq_pct = 85;
        default: enq_pct = 97;
      endcase
      gaps_on = (seg < 12) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 38; k++) begin
        it = random_fields();
        it.opcode = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::OP_ENQUEUE
                                                         : spq_pkg::OP_DEQUEUE;
        // narrow priorities half the time to force ties
        if ($urandom_range(0, 1) == 1) it.prio = 8'($urandom_range(0, 3));
        send_item(it);
        if (gaps_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 7));
      end
      if (seg == 6) drain_queue_results();
    end

    drain_queue_results();
    repeat (QDEPTH + 4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
